// ----- sv/lpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpc_pkg: shared types and constants of the lattice path counter
// Holds the fixed field widths, the sequencer state type and the table of
// square offsets around the guard that are closed to paths.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int unsigned COORD_W = 5;
  localparam int unsigned COUNT_W = 38;
  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } lpc_state_e;

  typedef struct packed {
    logic [COORD_W-1:0] dr;
    logic [COORD_W-1:0] dc;
  } lpc_offset_t;

  // Absolute row/column distance from the guard: the two knight-move shapes
  // and the guard square itself.
  localparam int unsigned NUM_OFS = 3;
  localparam lpc_offset_t GUARD_OFS [NUM_OFS] = '{
    '{dr: 5'd1, dc: 5'd2},
    '{dr: 5'd2, dc: 5'd1},
    '{dr: 5'd0, dc: 5'd0}
  };

endpackage

// ----- sv/lpc_ram.sv -----
// ----------------------------------------------------------------------------
// lpc_ram: generic single-clock RAM
// One write port and one read port; the read data is registered, and a read
// of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module lpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/lattice_path_counter.sv -----
// ----------------------------------------------------------------------------
// lattice_path_counter: monotone lattice path count with a knight-guarded cell
// Counts right/down paths from (0,0) to a target corner that avoid a guard
// square and its knight-move squares, by row-wise dynamic programming over a
// row buffer held in a RAM.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Transaction                      tdata / tuser
//  -------  ---  -------------------------------  ------------------------------
//  s_axis   in   one query                        target_x, target_y, guard_x,
//                                                 guard_y (5 bits each)
//  m_axis   out  one result per query             path_count (38 bits)
//
// Sequencing: a query is swept cell by cell over the rectangle up to the
// target, clamped to GRID_MAX. The next query is taken in the cycle after
// the result is loaded into the output register, never while one is in
// flight. The sweep is paced by the single row-buffer RAM, which delivers
// the count of the cell above once per cycle.
// Reset: rst_ni clears the sequencer and the output valid; the row buffer
// needs no clearing, since row 0 is computed with a zero row above it.
// Stalls: a new query is taken only while the sequencer is idle; a finished
// count waits in the sequencer until the output register is free.
//
module lattice_path_counter #(
  parameter int unsigned GRID_MAX = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [4:0] target_x, [9:5] target_y, [14:10] guard_x, [19:15] guard_y,
  // [23:20] zero
  input  logic [lpc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [37:0] path_count, [39:38] zero
  output logic [lpc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  import lpc_pkg::*;

  localparam int unsigned DEPTH = GRID_MAX + 1;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  // Width wide enough for both a grid index and a raw 5-bit coordinate.
  localparam int unsigned CW = (IDX_W > COORD_W) ? IDX_W : COORD_W;

  lpc_state_e state_q, state_d;

  logic [IDX_W-1:0]   tx_q, ty_q;
  logic [COORD_W-1:0] gx_q, gy_q;
  logic [IDX_W-1:0]   i_q, j_q;
  logic [COUNT_W-1:0] val_q;
  logic               fwd_q;
  logic               m_valid_q;
  logic [COUNT_W-1:0] m_data_q;

  logic               accept;
  logic               out_load;
  logic               last_col, last_row, last_cell;
  logic [IDX_W-1:0]   nj;
  logic               fwd_d;
  logic [CW-1:0]      tx_ext, ty_ext;
  logic [IDX_W-1:0]   tx_sat, ty_sat;
  logic [CW-1:0]      dr, dc;
  logic               blocked;
  logic [COUNT_W-1:0] rdata;
  logic [COUNT_W-1:0] above, left;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] cell_v;
  logic               ram_re, ram_we;
  logic [IDX_W-1:0]   ram_raddr;

  // Query fields, clamped to the grid.
  assign tx_ext = CW'(s_axis_tdata[COORD_W-1:0]);
  assign ty_ext = CW'(s_axis_tdata[2*COORD_W-1:COORD_W]);
  assign tx_sat = (tx_ext > CW'(GRID_MAX)) ? IDX_W'(GRID_MAX) : IDX_W'(tx_ext);
  assign ty_sat = (ty_ext > CW'(GRID_MAX)) ? IDX_W'(GRID_MAX) : IDX_W'(ty_ext);

  assign accept = s_axis_tvalid && s_axis_tready;

  // Position bookkeeping of the current cell.
  assign last_col  = (j_q == ty_q);
  assign last_row  = (i_q == tx_q);
  assign last_cell = last_col && last_row;
  assign nj        = last_col ? '0 : j_q + IDX_W'(1);
  // The next cell reads the entry written now only when the grid has a
  // single column; that value is taken from val_q instead of the RAM.
  assign fwd_d     = (nj == j_q);

  // Guard test: distances to the guard compared against the offset table.
  always_comb begin
    dr = (CW'(i_q) > CW'(gx_q)) ? CW'(i_q) - CW'(gx_q) : CW'(gx_q) - CW'(i_q);
    dc = (CW'(j_q) > CW'(gy_q)) ? CW'(j_q) - CW'(gy_q) : CW'(gy_q) - CW'(j_q);
    blocked = 1'b0;
    for (int k = 0; k < NUM_OFS; k++) begin
      if (dr == CW'(GUARD_OFS[k].dr) && dc == CW'(GUARD_OFS[k].dc)) begin
        blocked = 1'b1;
      end
    end
  end

  // Cell update: count from above plus count from the left, saturated.
  // Row 0 sees an empty row above it, column 0 an empty cell to its left.
  always_comb begin
    if (i_q == '0) begin
      above = '0;
    end else if (fwd_q) begin
      above = val_q;
    end else begin
      above = rdata;
    end
    left = (j_q == '0) ? '0 : val_q;
    sum  = {1'b0, above} + {1'b0, left};
    if (i_q == '0 && j_q == '0) begin
      cell_v = COUNT_W'(1);
    end else if (blocked) begin
      cell_v = '0;
    end else if (sum[COUNT_W]) begin
      cell_v = '1;
    end else begin
      cell_v = sum[COUNT_W-1:0];
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_cell) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output logic of the sequencer: handshake and RAM control.
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = '0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_re        = accept;
      end
      ST_RUN: begin
        ram_we    = 1'b1;
        ram_re    = !last_cell;
        ram_raddr = nj;
      end
      ST_DONE: begin
        out_load = !m_valid_q || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  lpc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (j_q),
    .wdata_i (cell_v),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      fwd_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        i_q   <= '0;
        j_q   <= '0;
        fwd_q <= 1'b0;
      end else if (state_q == ST_RUN && !last_cell) begin
        j_q   <= nj;
        fwd_q <= fwd_d;
        if (last_col) begin
          i_q <= i_q + IDX_W'(1);
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tx_q <= tx_sat;
      ty_q <= ty_sat;
      gx_q <= s_axis_tdata[3*COORD_W-1:2*COORD_W];
      gy_q <= s_axis_tdata[4*COORD_W-1:3*COORD_W];
    end
    if (state_q == ST_RUN) begin
      val_q <= cell_v;
    end
    if (out_load) begin
      m_data_q <= val_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(m_data_q);

`ifndef SYNTHESIS
  // Forwarding from val_q is only needed for a one-column grid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && fwd_q) |-> (ty_q == '0))
    else $error("row buffer forwarding outside a one-column grid");

  // The cell walk never leaves the target rectangle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (i_q <= tx_q && j_q <= ty_q))
    else $error("cell position beyond the target corner");

  // A result appears only after the sequencer has finished a query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result presented without a finished query");

  // An accepted query always starts at the start cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RUN && i_q == '0 && j_q == '0))
    else $error("query did not start at the start cell");
`endif

endmodule

// ----- verif/lattice_path_counter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lattice_path_counter_tb: self-checking testbench of the lattice path counter
// Sends path-count queries over the input stream and checks every returned
// count against a behavioral model of the guarded-grid dynamic program.
// ----------------------------------------------------------------------------
module lattice_path_counter_tb;
  import lpc_pkg::*;

  // The block is built with its default grid; the model must agree with it.
  localparam int unsigned GRID_MAX = 20;
  // Cycles to keep watching the output once nothing is pending. The span is
  // longer than the longest query, so a stray result would show up within it.
  localparam int unsigned DRAIN_CYCLES = 450;
  // The slowest legal run is about 1330 queries, each at its longest and
  // counting the longest sender gap and the longest output stall. The limit
  // is several times the length of that run.
  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  // One query as it is packed on s_axis_tdata, target_x in the lowest bits.
  typedef struct packed {
    logic [COORD_W-1:0] guard_y;
    logic [COORD_W-1:0] guard_x;
    logic [COORD_W-1:0] target_y;
    logic [COORD_W-1:0] target_x;
  } query_t;

  typedef struct {
    query_t             query;
    logic [COUNT_W-1:0] count;
  } path_count_entry_t;

  logic                   clk = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [4:0] target_x, [9:5] target_y, [14:10] guard_x, [19:15] guard_y,
  // [23:20] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [37:0] path_count, [39:38] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Counts that the block still owes us, oldest first.
  path_count_entry_t pending_counts[$];

  // When cleared, neither the sender nor the receiver inserts idle cycles.
  bit idle_enable = 1'b1;

  int unsigned sent_count    = 0;
  int unsigned checked_count = 0;
  int unsigned zero_count    = 0;
  int unsigned clamped_count = 0;
  int unsigned error_count   = 0;

  lattice_path_counter #(
    .GRID_MAX(GRID_MAX)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Behavioral model. The grid is swept row by row; each cell adds the count
  // of the cell above (still in the buffer) and the cell to its left. Cells
  // on the guard or a knight's move away from it hold zero, except the start
  // cell, which always holds one. Targets past the grid edge are clamped.
  function automatic logic [COUNT_W-1:0] count_guarded_paths(query_t q);
    logic [COUNT_W-1:0] row_buf [GRID_MAX+1];
    logic [COUNT_W:0]   sum;
    int                 rows;
    int                 cols;
    int                 gx;
    int                 gy;
    int                 dr;
    int                 dc;
    rows = (q.target_x > GRID_MAX) ? GRID_MAX : int'(q.target_x);
    cols = (q.target_y > GRID_MAX) ? GRID_MAX : int'(q.target_y);
    gx = int'(q.guard_x);
    gy = int'(q.guard_y);
    foreach (row_buf[k]) row_buf[k] = '0;
    for (int i = 0; i <= rows; i++) begin
      for (int j = 0; j <= cols; j++) begin
        dr = (i > gx) ? i - gx : gx - i;
        dc = (j > gy) ? j - gy : gy - j;
        if (i == 0 && j == 0) begin
          row_buf[j] = COUNT_W'(1);
        end else if ((dr == 1 && dc == 2) || (dr == 2 && dc == 1) ||
                     (dr == 0 && dc == 0)) begin
          row_buf[j] = '0;
        end else begin
          sum = {1'b0, row_buf[j]};
          if (j > 0) begin
            sum = sum + {1'b0, row_buf[j-1]};
          end
          // Only reachable on grids larger than the default one.
          row_buf[j] = sum[COUNT_W] ? COUNT_SAT : sum[COUNT_W-1:0];
        end
      end
    end
    return row_buf[cols];
  endfunction

  function automatic query_t make_query(int tx, int ty, int gx, int gy);
    query_t q;
    q.target_x = COORD_W'(tx);
    q.target_y = COORD_W'(ty);
    q.guard_x  = COORD_W'(gx);
    q.guard_y  = COORD_W'(gy);
    return q;
  endfunction

  // Random query. Most targets are small to keep the run short; a share spans
  // the whole grid and a few lie near or past its edge. The guard mostly falls
  // inside the swept rectangle, where it actually cuts paths, and otherwise
  // anywhere in the 5-bit range or around the grid border.
  function automatic query_t random_query();
    query_t q;
    int     pick;
    int     rows;
    int     cols;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      q.target_x = COORD_W'($urandom_range(0, 7));
      q.target_y = COORD_W'($urandom_range(0, 7));
    end else if (pick < 92) begin
      q.target_x = COORD_W'($urandom_range(0, GRID_MAX));
      q.target_y = COORD_W'($urandom_range(0, GRID_MAX));
    end else begin
      q.target_x = COORD_W'($urandom_range(15, 31));
      q.target_y = COORD_W'($urandom_range(15, 31));
    end
    rows = (q.target_x > GRID_MAX) ? GRID_MAX : int'(q.target_x);
    cols = (q.target_y > GRID_MAX) ? GRID_MAX : int'(q.target_y);
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      q.guard_x = COORD_W'($urandom_range(0, rows + 1));
      q.guard_y = COORD_W'($urandom_range(0, cols + 1));
    end else if (pick < 85) begin
      q.guard_x = COORD_W'($urandom_range(0, 31));
      q.guard_y = COORD_W'($urandom_range(0, 31));
    end else begin
      q.guard_x = COORD_W'($urandom_range(GRID_MAX - 2, GRID_MAX + 3));
      q.guard_y = COORD_W'($urandom_range(0, 31));
    end
    return q;
  endfunction

  // Sends one query and records its expected count once the transaction
  // completes. It is entered on a rising edge; tvalid stays high across
  // back-to-back queries and is only dropped for a random gap.
  task automatic send_query(query_t q);
    logic [COUNT_W-1:0] count;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - $bits(query_t)){1'b0}}, q};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    count = count_guarded_paths(q);
    pending_counts.push_back('{query: q, count: count});
    sent_count++;
    if (count == '0) zero_count++;
    if (q.target_x > GRID_MAX || q.target_y > GRID_MAX) clamped_count++;
  endtask

  // Holds the input idle until every outstanding count has come back.
  task automatic wait_for_counts();
    s_axis_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
  endtask

  // Corner cases: blocked start cell, the full grid with and without a
  // guard, clamped targets, a guard on or a knight's move from the target,
  // a guard that closes the only row or column, and guards off the grid.
  task automatic test_directed_corners();
    query_t corners[$];
    corners = '{
      make_query( 0,  0,  0,  0),   // start cell is the guard
      make_query( 0,  0,  1,  2),   // start cell is a knight square
      make_query( 0,  0, 31, 31),
      make_query(20, 20, 31, 31),   // whole grid, nothing blocked
      make_query(31, 31, 31, 31),   // both target coordinates clamped
      make_query(31,  0,  0, 31),
      make_query( 0, 31, 31,  0),
      make_query(20, 20, 10, 10),
      make_query(20, 20, 20, 20),   // guard on the target
      make_query(20, 20, 19, 18),   // target a knight's move from the guard
      make_query( 0, 20,  0,  5),   // single row cut by the guard
      make_query(20,  0,  5,  0),   // single column cut by the guard
      make_query(20, 20, 21, 10),   // guard just past the last row
      make_query(20, 20, 22, 20),
      make_query( 5,  7,  1,  1),
      make_query( 1,  1,  0,  0),
      make_query( 2,  1,  0,  0),
      make_query(21, 21,  0,  0),
      make_query(10, 10,  2,  1),
      make_query(16, 15, 31,  0),
      make_query(20, 20,  0,  1)
    };
    foreach (corners[k]) send_query(corners[k]);
  endtask

  // Bulk random traffic. Every hundred queries the idle mode is redrawn, so
  // some stretches run with gaps and stalls and others run flat out.
  task automatic test_random_mix(int unsigned num_queries);
    for (int unsigned n = 0; n < num_queries; n++) begin
      if (n % 100 == 0) idle_enable = ($urandom_range(0, 3) != 0);
      send_query(random_query());
    end
    idle_enable = 1'b1;
  endtask

  // The sender stops until the block has handed back every count, so that
  // the next query lands on a fully idle block.
  task automatic test_drain_pause(int unsigned num_queries);
    for (int unsigned n = 0; n < num_queries; n++) send_query(random_query());
    wait_for_counts();
    for (int unsigned n = 0; n < num_queries; n++) send_query(random_query());
  endtask

  // Closing stretch with no idle cycles on either side.
  task automatic test_tail_no_idle(int unsigned num_queries);
    idle_enable = 1'b0;
    for (int unsigned n = 0; n < num_queries; n++) send_query(random_query());
  endtask

  // Receiver: tready drops for random bursts while idling is enabled. One
  // assignment per edge keeps the drive unambiguous.
  initial begin : output_backpressure
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker. Each output transaction is matched against the oldest
  // pending count; signals are read at the edge before any update lands.
  always @(posedge clk) begin : check_counts
    path_count_entry_t oldest;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_counts.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("Unexpected result: path_count %0d with no query pending",
                   m_axis_tdata[COUNT_W-1:0]);
        end
      end else begin
        oldest = pending_counts.pop_front();
        checked_count++;
        if (m_axis_tdata[COUNT_W-1:0] !== oldest.count) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("Mismatch target (%0d,%0d) guard (%0d,%0d): path_count %0d, expected %0d",
                     oldest.query.target_x, oldest.query.target_y,
                     oldest.query.guard_x, oldest.query.guard_y,
                     m_axis_tdata[COUNT_W-1:0], oldest.count);
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Timeout after %0d cycles, %0d counts still pending",
             LIMIT_CYCLES, pending_counts.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main_sequence
    // Reset is held low from the start and released on a clock edge.
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_drain_pause(20);
    test_random_mix(1000);
    test_tail_no_idle(270);

    // Let the last counts come home, then watch for anything extra.
    wait_for_counts();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d queries and checked %0d counts (%0d zero, %0d with a clamped target).",
             sent_count, checked_count, zero_count, clamped_count);
    $display("Covered blocked start, guards on and off the grid, idle gaps and output stalls.");
    if (error_count == 0 && pending_counts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/lpc_pkg.sv
sv/lpc_ram.sv
sv/lattice_path_counter.sv
verif/lattice_path_counter_tb.sv
